// File: hdl/spt_pkg.sv
// Shared types, constants and the CORDIC angle table for the stereo triangulation block.
`default_nettype none
package spt_pkg;

   localparam int COORD_BITS   = 12;
   localparam int CORDIC_STEPS = 16;
   localparam int DIV_STEPS    = 32;
   localparam int ATAN_LEN     = 24;
   localparam int HALF_TURN    = 180;
   localparam int AZ_LIMIT     = HALF_TURN * 128;
   localparam int LAST_STAGE   = DIV_STEPS + 2;

   localparam logic [11:0] COORD_MASK = 12'((1 << COORD_BITS) - 1);

   typedef enum logic [2:0] {
      CSR_FOCAL_X  = 3'd0,
      CSR_FOCAL_Y  = 3'd1,
      CSR_CENTER_X = 3'd2,
      CSR_CENTER_Y = 3'd3,
      CSR_BASELINE = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [11:0] left_col;
      logic [11:0] left_row;
      logic [11:0] right_col;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] depth;
      logic signed [15:0] azimuth_deg;
      logic               zero_disparity;
      logic               saturated;
   } rsp_type;

   // One pipeline stage; lanes 0/1/2 = depth, pos_x, pos_y
   typedef struct packed {
      logic               vld;
      logic               zd;
      logic               dneg;
      logic               oxneg;
      logic               oyneg;
      logic [11:0]        ad;
      logic [15:0]        aox;
      logic [15:0]        aoy;
      logic signed [16:0] ox;
      logic [31:0]        fb;
      logic [31:0]        box;
      logic [27:0]        dg;
      logic [2:0]         ovf;
      logic [2:0][31:0]   rem;
      logic [2:0][31:0]   nq;
      logic [2:0][31:0]   den;
      logic signed [27:0] cx;
      logic signed [27:0] cy;
      logic signed [24:0] cz;
   } stg_type;

   // atan(2^-i) in 2^-16 degree
   function automatic logic [22:0] atan_val(input int i);
      logic [22:0] v;
      case (i)
         0:  v = 23'd2949120;
         1:  v = 23'd1740967;
         2:  v = 23'd919879;
         3:  v = 23'd466945;
         4:  v = 23'd234379;
         5:  v = 23'd117304;
         6:  v = 23'd58666;
         7:  v = 23'd29335;
         8:  v = 23'd14668;
         9:  v = 23'd7334;
         10: v = 23'd3667;
         11: v = 23'd1833;
         12: v = 23'd917;
         13: v = 23'd458;
         14: v = 23'd229;
         15: v = 23'd115;
         16: v = 23'd57;
         17: v = 23'd29;
         18: v = 23'd14;
         19: v = 23'd7;
         20: v = 23'd4;
         21: v = 23'd2;
         22: v = 23'd1;
         default: v = 23'd0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

// File: hdl/stereo_point_triangulation_top.sv
// Top level: fully pipelined stereo point triangulation with CORDIC azimuth.
`default_nettype none
// One matched point (left column, left row, right column) enters per clock while
// req_stall is low; a result beat holds pos_x, pos_y, depth in Q23.8, azimuth in
// Q8.8 degrees and flags. The pipeline depth is set by the three restoring
// dividers, which retire one quotient bit per stage; the CORDIC runs one
// micro-rotation per stage alongside the first CORDIC_STEPS of them. Sustained
// rate is one beat per cycle unless the output stalls. When rsp_stall holds a
// waiting result, the whole pipeline freezes and req_stall rises in the same
// cycle; nothing is dropped or repeated. csr_ready is always high; registers
// are read live by the pipeline, so write them only while the block is empty.
module stereo_point_triangulation_top (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire spt_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output spt_pkg::rsp_type     rsp_data,
   input  wire logic            csr_valid,
   output logic                 csr_ready,
   input  wire logic [2:0]      csr_index,
   input  wire logic [15:0]     csr_data
);
   import spt_pkg::*;

   // configuration registers
   logic [15:0] focal_x_ff, focal_y_ff, center_x_ff, center_y_ff, baseline_ff;

   stg_type pipe_ff [0:LAST_STAGE];
   stg_type pipe_in [0:LAST_STAGE];

   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff;
   logic    adv;

   // pipeline advances when the output register is empty or being drained
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_x_ff  <= 16'd16;
         focal_y_ff  <= 16'd16;
         center_x_ff <= 16'd0;
         center_y_ff <= 16'd0;
         baseline_ff <= 16'd256;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FOCAL_X:  focal_x_ff  <= csr_data;
            CSR_FOCAL_Y:  focal_y_ff  <= csr_data;
            CSR_CENTER_X: center_x_ff <= csr_data;
            CSR_CENTER_Y: center_y_ff <= csr_data;
            CSR_BASELINE: baseline_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // stage logic
   always_comb begin
      logic [11:0]        lc, lr, rc;
      logic [12:0]        d13, nd13;
      logic [16:0]        ox17, nox17, oy17, noy17;
      logic [15:0]        geff;
      logic [47:0]        num [0:2];
      logic [32:0]        r;
      logic               ge;
      logic signed [27:0] xs, ys;
      logic signed [24:0] ang;

      // stage 0: disparity and principal point offsets
      lc    = req_data.left_col  & COORD_MASK;
      lr    = req_data.left_row  & COORD_MASK;
      rc    = req_data.right_col & COORD_MASK;
      d13   = {1'b0, rc} - {1'b0, lc};
      nd13  = 13'd0 - d13;
      ox17  = {1'b0, lc, 4'b0} - {1'b0, center_x_ff};
      nox17 = 17'd0 - ox17;
      oy17  = {1'b0, lr, 4'b0} - {1'b0, center_y_ff};
      noy17 = 17'd0 - oy17;
      geff  = (focal_y_ff == 16'd0) ? 16'd1 : focal_y_ff;

      pipe_in[0]       = pipe_ff[0];
      pipe_in[0].vld   = req_valid;
      pipe_in[0].zd    = (d13 == 13'd0);
      pipe_in[0].dneg  = d13[12];
      pipe_in[0].ad    = d13[12] ? nd13[11:0] : d13[11:0];
      pipe_in[0].oxneg = ox17[16];
      pipe_in[0].aox   = ox17[16] ? nox17[15:0] : ox17[15:0];
      pipe_in[0].oyneg = oy17[16];
      pipe_in[0].aoy   = oy17[16] ? noy17[15:0] : oy17[15:0];
      pipe_in[0].ox    = $signed(ox17);

      // stage 1: first products, CORDIC start vector
      pipe_in[1]     = pipe_ff[0];
      pipe_in[1].fb  = 32'(focal_x_ff) * 32'(baseline_ff);
      pipe_in[1].box = 32'(baseline_ff) * 32'(pipe_ff[0].aox);
      pipe_in[1].dg  = 28'(pipe_ff[0].ad) * 28'(geff);
      pipe_in[1].cx  = $signed({4'b0, focal_x_ff, 8'b0});
      pipe_in[1].cy  = $signed({{3{pipe_ff[0].ox[16]}}, pipe_ff[0].ox, 8'b0});
      pipe_in[1].cz  = '0;

      // stage 2: dividends, divisors, quotient range check
      num[0] = 48'(pipe_ff[1].fb);
      num[1] = 48'(pipe_ff[1].box);
      num[2] = 48'(pipe_ff[1].fb) * 48'(pipe_ff[1].aoy);
      pipe_in[2]        = pipe_ff[1];
      pipe_in[2].den[0] = 32'({pipe_ff[1].ad, 4'b0});
      pipe_in[2].den[1] = 32'({pipe_ff[1].ad, 4'b0});
      pipe_in[2].den[2] = {pipe_ff[1].dg, 4'b0};
      for (int j = 0; j < 3; j++) begin
         pipe_in[2].ovf[j] = 32'(num[j][47:32]) >= pipe_in[2].den[j];
         pipe_in[2].rem[j] = 32'(num[j][47:32]);
         pipe_in[2].nq[j]  = num[j][31:0];
      end

      // divider bit steps, CORDIC rotations alongside
      for (int k = 0; k < DIV_STEPS; k++) begin
         pipe_in[k+3] = pipe_ff[k+2];
         for (int j = 0; j < 3; j++) begin
            r  = {pipe_ff[k+2].rem[j], pipe_ff[k+2].nq[j][31]};
            ge = r >= {1'b0, pipe_ff[k+2].den[j]};
            pipe_in[k+3].rem[j] = ge ? 32'(r - {1'b0, pipe_ff[k+2].den[j]}) : r[31:0];
            pipe_in[k+3].nq[j]  = {pipe_ff[k+2].nq[j][30:0], ge};
         end
         if (k < CORDIC_STEPS) begin
            xs  = pipe_ff[k+2].cx >>> k;
            ys  = pipe_ff[k+2].cy >>> k;
            ang = $signed({2'b0, atan_val(k)});
            if (pipe_ff[k+2].cy > 28'sd0) begin
               pipe_in[k+3].cx = pipe_ff[k+2].cx + ys;
               pipe_in[k+3].cy = pipe_ff[k+2].cy - xs;
               pipe_in[k+3].cz = pipe_ff[k+2].cz + ang;
            end else if (pipe_ff[k+2].cy < 28'sd0) begin
               pipe_in[k+3].cx = pipe_ff[k+2].cx - ys;
               pipe_in[k+3].cy = pipe_ff[k+2].cy + xs;
               pipe_in[k+3].cz = pipe_ff[k+2].cz - ang;
            end
         end
      end
   end

   // output stage: signs, saturation, azimuth rounding
   always_comb begin
      logic [31:0]        mag;
      logic               neg, clip, any_sat;
      logic [31:0]        val [0:2];
      logic signed [24:0] zr;
      logic signed [16:0] az;

      any_sat = 1'b0;
      for (int j = 0; j < 3; j++) begin
         mag = pipe_ff[LAST_STAGE].nq[j];
         case (j)
            0:       neg = pipe_ff[LAST_STAGE].dneg;
            1:       neg = pipe_ff[LAST_STAGE].dneg ^ pipe_ff[LAST_STAGE].oxneg;
            default: neg = pipe_ff[LAST_STAGE].dneg ^ pipe_ff[LAST_STAGE].oyneg;
         endcase
         clip = pipe_ff[LAST_STAGE].ovf[j] || (neg ? (mag > 32'h8000_0000) : mag[31]);
         if (clip) begin
            val[j] = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
         end else begin
            val[j] = neg ? (32'd0 - mag) : mag;
         end
         if (pipe_ff[LAST_STAGE].zd) begin
            val[j] = '0;
         end else begin
            any_sat = any_sat | clip;
         end
      end

      zr = (pipe_ff[LAST_STAGE].cz + 25'sd128) >>> 8;
      az = zr[16:0];
      if (az > 17'(AZ_LIMIT)) begin
         az = 17'(AZ_LIMIT);
      end else if (az < -17'(AZ_LIMIT)) begin
         az = -17'(AZ_LIMIT);
      end

      rsp_in.depth          = $signed(val[0]);
      rsp_in.pos_x          = $signed(val[1]);
      rsp_in.pos_y          = $signed(val[2]);
      rsp_in.azimuth_deg    = az[15:0];
      rsp_in.zero_disparity = pipe_ff[LAST_STAGE].zd;
      rsp_in.saturated      = any_sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= LAST_STAGE; s++) begin
            pipe_ff[s] <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         for (int s = 0; s <= LAST_STAGE; s++) begin
            pipe_ff[s] <= pipe_in[s];
         end
         rsp_ff       <= rsp_in;
         rsp_valid_ff <= pipe_ff[LAST_STAGE].vld;
      end
   end

endmodule
`default_nettype wire

// File: test/tb_stereo_point_triangulation_top.sv
// Self-checking testbench for the stereo point triangulation block.
`timescale 1ns / 1ps
`default_nettype none
// Each accepted point is run through a behavioural triangulator:
//  - exact integer division for depth, lateral and vertical position
//  - a bit-true vectoring CORDIC for the azimuth
// The predicted result is queued. Every result beat is then checked
// field by field against the oldest queued prediction.
// Both sides idle at random between beats, with calm stretches that run
// at full rate. Registers are only written while the pipe is empty.
module tb_stereo_point_triangulation_top;
   import spt_pkg::*;

   localparam logic [2:0] CSR_UNUSED = 3'd5;  // beyond the register map: ignored
   localparam int PIPE_DEPTH  = 36;
   localparam int DRAIN_WAIT  = PIPE_DEPTH + 8;
   localparam int CYCLE_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   // live copy of the register file
   longint focal_x, focal_y, center_x, center_y, baseline;

   rsp_type expected_points[$];
   int      mismatches = 0;
   int      points_sent = 0;
   int      points_seen = 0;
   int      zero_disp_seen = 0;
   int      clipped_seen = 0;
   int      cycles = 0;
   int      stall_left = 0;
   bit      calm = 1'b0;  // no idling on either side while set

   // atan(2^-i) in 2^-16 degree
   longint atan_step[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                             58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                             229, 115};

   stereo_point_triangulation_top uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic longint clip_q23(input longint v, inout bit sat);
      if (v > 64'sd2147483647) begin
         sat = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         sat = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   // vectoring CORDIC, angle rounded to Q8.8 degrees and clipped to +-90
   function automatic longint azimuth_q8(input longint x0, input longint y0);
      longint x, y, z, xs, ys;
      x = x0;
      y = y0;
      z = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x = x + ys;
            y = y - xs;
            z = z + atan_step[i];
         end else if (y < 0) begin
            x = x - ys;
            y = y + xs;
            z = z - atan_step[i];
         end
      end
      z = (z + 128) >>> 8;
      if (z > AZ_LIMIT) z = AZ_LIMIT;
      if (z < -AZ_LIMIT) z = -AZ_LIMIT;
      return z;
   endfunction

   function automatic rsp_type triangulate(input req_type p);
      rsp_type r;
      longint  disp, g, ox, oy, px, py, pz;
      bit      sat;
      disp = longint'(p.right_col) - longint'(p.left_col);
      g    = (focal_y == 0) ? 1 : focal_y;
      ox   = 16 * longint'(p.left_col) - center_x;
      oy   = 16 * longint'(p.left_row) - center_y;
      sat  = 1'b0;
      px   = 0;
      py   = 0;
      pz   = 0;
      // zero disparity: positions stay zero, azimuth still worked out
      if (disp != 0) begin
         pz = clip_q23((focal_x * baseline) / (16 * disp), sat);
         px = clip_q23((baseline * ox) / (16 * disp), sat);
         py = clip_q23((focal_x * baseline * oy) / (16 * disp * g), sat);
      end
      r.pos_x          = px[31:0];
      r.pos_y          = py[31:0];
      r.depth          = pz[31:0];
      r.azimuth_deg    = 16'(azimuth_q8(focal_x * 256, ox * 256));
      r.zero_disparity = (disp == 0);
      r.saturated      = sat;
      return r;
   endfunction

   // result side: random stall per beat, check each accepted beat
   always @(posedge clock) begin
      rsp_type want;
      cycles <= cycles + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         points_seen++;
         if (rsp_data.zero_disparity) zero_disp_seen++;
         if (rsp_data.saturated) clipped_seen++;
         if (expected_points.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat %p", rsp_data);
         end else begin
            want = expected_points.pop_front();
            if (rsp_data.pos_x !== want.pos_x || rsp_data.pos_y !== want.pos_y ||
                rsp_data.depth !== want.depth ||
                rsp_data.azimuth_deg !== want.azimuth_deg ||
                rsp_data.zero_disparity !== want.zero_disparity ||
                rsp_data.saturated !== want.saturated) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch on beat %0d", points_seen);
                  $display("  expected x=%0d y=%0d z=%0d az=%0d zd=%0b sat=%0b",
                           want.pos_x, want.pos_y, want.depth, want.azimuth_deg,
                           want.zero_disparity, want.saturated);
                  $display("  actual   x=%0d y=%0d z=%0d az=%0d zd=%0b sat=%0b",
                           rsp_data.pos_x, rsp_data.pos_y, rsp_data.depth,
                           rsp_data.azimuth_deg, rsp_data.zero_disparity,
                           rsp_data.saturated);
               end
            end
         end
         stall_left = calm ? 0 : $urandom_range(0, 19);
      end
      rsp_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
   end

   // watchdog
   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAILURE");
         $finish;
      end
   end

   // one point beat; valid stays high across back-to-back beats
   task automatic send_point(input logic [11:0] lc, input logic [11:0] lr,
                             input logic [11:0] rc);
      req_type p;
      int      gap;
      p.left_col  = lc;
      p.left_row  = lr;
      p.right_col = rc;
      gap = calm ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      do @(posedge clock); while (req_stall);
      expected_points.push_back(triangulate(p));
      points_sent++;
   endtask

   task automatic end_burst;
      req_valid <= 1'b0;
      wait (expected_points.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // write only with the pipe empty; registers are read live
   task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_FOCAL_X:  focal_x  = val;
         CSR_FOCAL_Y:  focal_y  = val;
         CSR_CENTER_X: center_x = val;
         CSR_CENTER_Y: center_y = val;
         CSR_BASELINE: baseline = val;
         default: ;
      endcase
   endtask

   task automatic load_regs(input logic [15:0] fx, input logic [15:0] fy,
                            input logic [15:0] cx, input logic [15:0] cy,
                            input logic [15:0] bl);
      write_reg(CSR_FOCAL_X, fx);
      write_reg(CSR_FOCAL_Y, fy);
      write_reg(CSR_CENTER_X, cx);
      write_reg(CSR_CENTER_Y, cy);
      write_reg(CSR_BASELINE, bl);
   endtask

   task automatic random_point;
      logic [11:0] lc, lr, rc;
      lc = 12'($urandom);
      lr = 12'($urandom);
      case ($urandom_range(0, 9))
         0:       rc = lc;                                 // zero disparity
         1, 2:    rc = lc + 12'($urandom_range(1, 8));     // near, big values
         3:       rc = lc - 12'($urandom_range(1, 8));
         default: rc = 12'($urandom);
      endcase
      send_point(lc, lr, rc);
   endtask

   // reset values straight after reset
   task automatic test_reset_config;
      send_point(12'd0, 12'd0, 12'd1);
      send_point(12'd100, 12'd200, 12'd90);
      send_point(12'd5, 12'd5, 12'd5);
      end_burst();
   endtask

   // field extremes, zero disparity, zero focal lengths, saturation
   task automatic test_extremes;
      load_regs(16'd8000, 16'd0, 16'd32000, 16'd32000, 16'hFFFF);  // focal_y zero acts as 1
      send_point(12'd0, 12'd0, 12'd4095);
      send_point(12'd4095, 12'd4095, 12'd0);
      send_point(12'd2000, 12'd4095, 12'd2001);   // clips vertical position
      send_point(12'd2000, 12'd0, 12'd1999);
      send_point(12'd1234, 12'd777, 12'd1234);    // zero disparity
      end_burst();
      load_regs(16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd1);          // focal_x zero
      send_point(12'd0, 12'd10, 12'd7);           // offset negative: -90
      send_point(12'd4095, 12'd10, 12'd4000);     // offset negative: -90
      send_point(12'd4095, 12'd0, 12'd4095);
      end_burst();
      load_regs(16'd0, 16'd1, 16'd160, 16'd0, 16'd0);              // offset zero: 0 deg
      send_point(12'd10, 12'd4095, 12'd11);
      send_point(12'd10, 12'd0, 12'd9);
      end_burst();
      load_regs(16'hFFFF, 16'd1, 16'd0, 16'hFFFF, 16'hFFFF);
      send_point(12'd1, 12'd0, 12'd2);
      send_point(12'd4095, 12'd4095, 12'd4094);
      send_point(12'd0, 12'd0, 12'd0);
      end_burst();
      write_reg(CSR_UNUSED, 16'hFFFF);            // ignored index
      send_point(12'd2048, 12'd2048, 12'd2050);
      end_burst();
   endtask

   // random points under a sequence of random and extreme settings
   task automatic test_random;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: load_regs(16'd16, 16'd16, 16'd0, 16'd0, 16'd256);
            1: load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            2: load_regs(16'd1, 16'd1, 16'd0, 16'd0, 16'd1);
            default: load_regs(16'($urandom_range(1, 65535)), 16'($urandom),
                               16'($urandom), 16'($urandom), 16'($urandom));
         endcase
         calm = (phase % 3 == 2);
         repeat (48) random_point();
         calm = 1'b0;
         end_burst();
      end
   endtask

   initial begin
      focal_x  = 16;
      focal_y  = 16;
      center_x = 0;
      center_y = 0;
      baseline = 256;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_config();
      test_extremes();
      test_random();
      $display("%0d points triangulated, %0d results checked", points_sent, points_seen);
      $display("%0d with zero disparity, %0d clipped, over 13 register settings",
               zero_disp_seen, clipped_seen);
      if (mismatches == 0 && expected_points.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("FAILURE");
      end
      $finish;
   end

endmodule
`default_nettype wire

// File: sim.f
hdl/spt_pkg.sv
hdl/stereo_point_triangulation_top.sv
test/tb_stereo_point_triangulation_top.sv
